[rtl/nat_port_translation_table_top_defines.svh]
// Assertion macros shared by the translation table RTL.
// Takes no other file; included by files that carry concurrent checks.
`ifndef NAT_PORT_TRANSLATION_TABLE_TOP_DEFINES_SVH
`define NAT_PORT_TRANSLATION_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npt: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NPT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npt: next-cycle check failed");

`endif

[rtl/npt_pkg.sv]
// Package for the NAPT port translation table: constants, status codes,
// the query word that travels along the cell chain. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package npt_pkg;

    localparam int DEF_TABLE_DEPTH = 64;

    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_NAT_ADDRESS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PORT  = CFG_IDX_W'(1);

    localparam logic [PORT_W-1:0] FIRST_PORT_RESET = PORT_W'(10000);

    localparam logic FUNC_OUTBOUND = 1'b0;
    localparam logic FUNC_INBOUND  = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_NEW      = 2'd1,
        ST_NO_MATCH = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Header plus search progress, handed from cell to cell.
    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] src_address;
        logic [ADDR_W-1:0] dest_address;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dest_port;
        logic              addr_ok;
        logic              found;
        logic [ADDR_W-1:0] hit_addr;
        logic [PORT_W-1:0] hit_port;
    } query_t;

endpackage

`default_nettype wire

[rtl/npt_if.sv]
// Handshake interfaces for the translation table: header request,
// translated response and register write. Depends on npt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface npt_req_if;
    import npt_pkg::*;
    logic              valid;
    logic              ready;
    logic              func;
    logic [ADDR_W-1:0] src_address;
    logic [ADDR_W-1:0] dest_address;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dest_port;

    modport source (output valid, func, src_address, dest_address, src_port, dest_port,
                    input ready);
    modport sink   (input valid, func, src_address, dest_address, src_port, dest_port,
                    output ready);
endinterface

interface npt_rsp_if;
    import npt_pkg::*;
    logic              valid;
    logic              ready;
    logic              forward;
    logic [1:0]        status;
    logic [ADDR_W-1:0] out_src_address;
    logic [ADDR_W-1:0] out_dest_address;
    logic [PORT_W-1:0] out_src_port;
    logic [PORT_W-1:0] out_dest_port;

    modport source (output valid, forward, status, out_src_address, out_dest_address,
                    out_src_port, out_dest_port, input ready);
    modport sink   (input valid, forward, status, out_src_address, out_dest_address,
                    out_src_port, out_dest_port, output ready);
endinterface

interface npt_cfg_if;
    import npt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/npt_cell.sv]
// One table entry of the translation chain: holds a mapping, compares the
// passing query word against it and appends itself when first free.
// Depends on npt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module npt_cell #(
    parameter int TABLE_DEPTH = npt_pkg::DEF_TABLE_DEPTH,
    parameter int CELL_INDEX  = 0
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             advance,
    input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] count,
    input  wire logic [npt_pkg::PORT_W-1:0]       next_port,
    input  wire logic                             prev_valid,
    input  wire npt_pkg::query_t                  prev_q,
    output logic                                  valid,
    output npt_pkg::query_t                       q
);
    import npt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(CELL_INDEX);

    logic [ADDR_W-1:0] int_addr_reg, int_addr_next;
    logic [PORT_W-1:0] int_port_reg, int_port_next;
    logic [PORT_W-1:0] ext_port_reg, ext_port_next;
    logic              valid_reg, valid_next;
    query_t            q_reg, q_next;

    logic live;
    logic match;
    logic append;

    assign live = (MY_INDEX < count);

    always_comb
    begin
        if (prev_q.func == FUNC_INBOUND)
        begin
            match = prev_q.addr_ok && (ext_port_reg == prev_q.dest_port);
        end
        else
        begin
            match = (int_addr_reg == prev_q.src_address) && (int_port_reg == prev_q.src_port);
        end
        match = match && live && !prev_q.found;
    end

    // Entries fill in order, so reaching the first free slot unmatched means a miss.
    assign append = prev_valid && advance && (prev_q.func == FUNC_OUTBOUND) && !prev_q.found
                    && (MY_INDEX == count);

    always_comb
    begin
        int_addr_next = int_addr_reg;
        int_port_next = int_port_reg;
        ext_port_next = ext_port_reg;
        if (append)
        begin
            int_addr_next = prev_q.src_address;
            int_port_next = prev_q.src_port;
            ext_port_next = next_port;
        end
    end

    always_comb
    begin
        q_next = prev_q;
        if (match)
        begin
            q_next.found = 1'b1;
            if (prev_q.func == FUNC_INBOUND)
            begin
                q_next.hit_addr = int_addr_reg;
                q_next.hit_port = int_port_reg;
            end
            else
            begin
                q_next.hit_addr = int_addr_reg;
                q_next.hit_port = ext_port_reg;
            end
        end
        if (!advance)
        begin
            q_next = q_reg;
        end
    end

    assign valid_next = advance ? prev_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        int_addr_reg  <= int_addr_next;
        int_port_reg  <= int_port_next;
        ext_port_reg  <= ext_port_next;
    end

    assign valid = valid_reg;
    assign q     = q_reg;

endmodule

`default_nettype wire

[rtl/nat_port_translation_table_top.sv]
// Top level of the NAPT port translation table: cell chain, counters,
// registers and response stage. Depends on npt_pkg, npt_if, npt_cell.
`timescale 1ns / 1ps
`default_nettype none
`include "nat_port_translation_table_top_defines.svh"

// Usage:
//   req  : one packet header word per transfer (func 0 outbound, 1 inbound).
//   rsp  : one translated header word per request, with forward and status;
//          dropped headers come back with forward 0 and all header fields 0.
//   cfg  : register writes, index 0 nat_address, index 1 first_port (loaded
//          into the port counter); other indexes are ignored. cfg.ready
//          is always high; write only while no request is outstanding.
// Timing: a request walks the chain of TABLE_DEPTH cells, one cell a cycle
//   while the chain is not frozen, then enters the response register. One request
//   is in the chain at a time; req.ready returns the cycle after the word
//   leaves the last cell.
// Stall: a response waiting on rsp.ready does not block the next request;
//   that request walks the chain and freezes in the last cell until the
//   response register is free.
// Reset: clears the table fill count, sets nat_address to 0 and the port
//   counter to 10000, and empties the chain and response register.
//   Table contents are not cleared; entries past the fill count are unused.
module nat_port_translation_table_top #(
    parameter int TABLE_DEPTH = npt_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    npt_cfg_if.sink   cfg,
    npt_req_if.sink   req,
    npt_rsp_if.source rsp
);
    import npt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    logic [ADDR_W-1:0] nat_address_reg, nat_address_next;
    logic [PORT_W-1:0] next_port_reg, next_port_next;
    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic              busy_reg, busy_next;
    logic              out_valid_reg, out_valid_next;

    logic              res_forward_reg, res_forward_next;
    status_t           res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_src_addr_reg, res_src_addr_next;
    logic [ADDR_W-1:0] res_dst_addr_reg, res_dst_addr_next;
    logic [PORT_W-1:0] res_src_port_reg, res_src_port_next;
    logic [PORT_W-1:0] res_dst_port_reg, res_dst_port_next;

    logic              cfg_write;
    logic              req_accept;
    logic              advance;
    logic              load;
    logic              new_entry;
    logic [CNT_W-1:0]  count_inc;
    logic              drop_shown;
    query_t            q_head;
    query_t            q_last;
    logic              last_valid;

    logic   [TABLE_DEPTH:0] chain_valid;
    query_t                 chain_q [TABLE_DEPTH+1];

    assign cfg.ready  = 1'b1;
    assign cfg_write  = cfg.valid && cfg.ready;
    assign req.ready  = !busy_reg;
    assign req_accept = req.valid && req.ready;

    always_comb
    begin
        q_head              = '0;
        q_head.func         = req.func;
        q_head.src_address  = req.src_address;
        q_head.dest_address = req.dest_address;
        q_head.src_port     = req.src_port;
        q_head.dest_port    = req.dest_port;
        q_head.addr_ok      = (req.dest_address == nat_address_reg);
    end

    assign chain_valid[0] = req_accept;
    assign chain_q[0]     = q_head;

    generate
        for (genvar g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            npt_cell #(
                .TABLE_DEPTH (TABLE_DEPTH),
                .CELL_INDEX  (g)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .advance    (advance),
                .count      (entry_count_reg),
                .next_port  (next_port_reg),
                .prev_valid (chain_valid[g]),
                .prev_q     (chain_q[g]),
                .valid      (chain_valid[g+1]),
                .q          (chain_q[g+1])
            );
        end
    endgenerate

    assign last_valid = chain_valid[TABLE_DEPTH];
    assign q_last     = chain_q[TABLE_DEPTH];

    // Freeze the chain while the last cell holds a word the response stage cannot take.
    assign advance = !(last_valid && out_valid_reg && !rsp.ready);
    assign load    = last_valid && advance;

    always_comb
    begin
        res_forward_next  = res_forward_reg;
        res_status_next   = res_status_reg;
        res_src_addr_next = res_src_addr_reg;
        res_dst_addr_next = res_dst_addr_reg;
        res_src_port_next = res_src_port_reg;
        res_dst_port_next = res_dst_port_reg;
        if (load)
        begin
            if (q_last.found && (q_last.func == FUNC_INBOUND))
            begin
                res_forward_next  = 1'b1;
                res_status_next   = ST_HIT;
                res_src_addr_next = q_last.src_address;
                res_dst_addr_next = q_last.hit_addr;
                res_src_port_next = q_last.src_port;
                res_dst_port_next = q_last.hit_port;
            end
            else if (q_last.found)
            begin
                res_forward_next  = 1'b1;
                res_status_next   = ST_HIT;
                res_src_addr_next = nat_address_reg;
                res_dst_addr_next = q_last.dest_address;
                res_src_port_next = q_last.hit_port;
                res_dst_port_next = q_last.dest_port;
            end
            else if ((q_last.func == FUNC_INBOUND) || (entry_count_reg == FULL_COUNT))
            begin
                res_forward_next  = 1'b0;
                res_status_next   = (q_last.func == FUNC_INBOUND) ? ST_NO_MATCH : ST_FULL;
                res_src_addr_next = '0;
                res_dst_addr_next = '0;
                res_src_port_next = '0;
                res_dst_port_next = '0;
            end
            else
            begin
                res_forward_next  = 1'b1;
                res_status_next   = ST_NEW;
                res_src_addr_next = nat_address_reg;
                res_dst_addr_next = q_last.dest_address;
                res_src_port_next = next_port_reg;
                res_dst_port_next = q_last.dest_port;
            end
        end
    end

    assign new_entry  = load && (res_status_next == ST_NEW);
    assign count_inc  = entry_count_reg + CNT_W'(1);
    assign drop_shown = out_valid_reg && !res_forward_reg;

    always_comb
    begin
        nat_address_next = nat_address_reg;
        next_port_next   = next_port_reg;
        entry_count_next = entry_count_reg;
        if (new_entry)
        begin
            entry_count_next = count_inc;
            next_port_next   = next_port_reg + PORT_W'(1);
        end
        if (cfg_write && (cfg.index == CFG_NAT_ADDRESS))
        begin
            nat_address_next = cfg.data[ADDR_W-1:0];
        end
        if (cfg_write && (cfg.index == CFG_FIRST_PORT))
        begin
            next_port_next = cfg.data[PORT_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (req_accept)
        begin
            busy_next = 1'b1;
        end
        else if (load)
        begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nat_address_reg <= '0;
            next_port_reg   <= FIRST_PORT_RESET;
            entry_count_reg <= '0;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            nat_address_reg <= nat_address_next;
            next_port_reg   <= next_port_next;
            entry_count_reg <= entry_count_next;
            busy_reg        <= busy_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_forward_reg  <= res_forward_next;
        res_status_reg   <= res_status_next;
        res_src_addr_reg <= res_src_addr_next;
        res_dst_addr_reg <= res_dst_addr_next;
        res_src_port_reg <= res_src_port_next;
        res_dst_port_reg <= res_dst_port_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.forward          = res_forward_reg;
    assign rsp.status           = res_status_reg;
    assign rsp.out_src_address  = res_src_addr_reg;
    assign rsp.out_dest_address = res_dst_addr_reg;
    assign rsp.out_src_port     = res_src_port_reg;
    assign rsp.out_dest_port    = res_dst_port_reg;

    `NPT_ASSERT_IMP(a_one_word, clk, rst_n, 1'b1, $countones(chain_valid[TABLE_DEPTH:1]) <= 1)
    `NPT_ASSERT_IMP(a_count_bounded, clk, rst_n, 1'b1, entry_count_reg <= FULL_COUNT)
    `NPT_ASSERT_IMP(a_chain_only_when_busy, clk, rst_n, |chain_valid[TABLE_DEPTH:1], busy_reg)
    `NPT_ASSERT_NEXT(a_new_bump, clk, rst_n, new_entry, entry_count_reg == $past(count_inc))
    `NPT_ASSERT_IMP(a_drop_zero, clk, rst_n, drop_shown, ~|{res_src_addr_reg, res_dst_port_reg})

endmodule

`default_nettype wire

[tb/sv/nat_port_translation_table_checker.sv]
// Scoreboard for the NAPT translation table: watches the register, header and
// response channels, predicts every translated header and compares it.
// Depends on npt_pkg and the channel interfaces in npt_if.
`timescale 1ns / 1ps

module nat_port_translation_table_checker #(
    parameter int TABLE_DEPTH = npt_pkg::DEF_TABLE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    npt_cfg_if   cfg,
    npt_req_if   req,
    npt_rsp_if   rsp,
    output int   failures,
    output int   results_seen
);
    import npt_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] int_addr;
        logic [PORT_W-1:0] int_port;
        logic [PORT_W-1:0] ext_port;
    } flow_t;

    typedef struct packed {
        logic              forward;
        status_t           status;
        logic [ADDR_W-1:0] src_address;
        logic [ADDR_W-1:0] dest_address;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dest_port;
    } xlat_t;

    flow_t             flow_tab[$];
    xlat_t             pending_xlat[$];
    logic [ADDR_W-1:0] nat_addr;
    logic [PORT_W-1:0] port_next;
    int                status_seen[4];

    function automatic xlat_t translate_header(input logic func,
                                               input logic [ADDR_W-1:0] sa,
                                               input logic [ADDR_W-1:0] da,
                                               input logic [PORT_W-1:0] sp,
                                               input logic [PORT_W-1:0] dp);
        xlat_t r;
        flow_t fresh;
        bit    done;
        r = '0;
        r.status = ST_NO_MATCH;
        done = 1'b0;
        if (func == FUNC_INBOUND)
        begin
            // first entry with this external port wins
            if (da == nat_addr)
            begin
                foreach (flow_tab[i])
                begin
                    if (!done && flow_tab[i].ext_port == dp)
                    begin
                        r.forward      = 1'b1;
                        r.status       = ST_HIT;
                        r.src_address  = sa;
                        r.dest_address = flow_tab[i].int_addr;
                        r.src_port     = sp;
                        r.dest_port    = flow_tab[i].int_port;
                        done = 1'b1;
                    end
                end
            end
        end
        else
        begin
            foreach (flow_tab[i])
            begin
                if (!done && flow_tab[i].int_addr == sa && flow_tab[i].int_port == sp)
                begin
                    r.forward      = 1'b1;
                    r.status       = ST_HIT;
                    r.src_address  = nat_addr;
                    r.dest_address = da;
                    r.src_port     = flow_tab[i].ext_port;
                    r.dest_port    = dp;
                    done = 1'b1;
                end
            end
            if (!done)
            begin
                if (flow_tab.size() >= TABLE_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    fresh.int_addr = sa;
                    fresh.int_port = sp;
                    fresh.ext_port = port_next;
                    flow_tab.insert(flow_tab.size(), fresh);
                    r.forward      = 1'b1;
                    r.status       = ST_NEW;
                    r.src_address  = nat_addr;
                    r.dest_address = da;
                    r.src_port     = port_next;
                    r.dest_port    = dp;
                    port_next++;
                end
            end
        end
        status_seen[r.status]++;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        xlat_t want;
        xlat_t fresh;
        if (!rst_n)
        begin
            flow_tab.delete();
            pending_xlat.delete();
            nat_addr     = '0;
            port_next    = FIRST_PORT_RESET;
            failures     = 0;
            results_seen = 0;
            status_seen  = '{default: 0};
        end
        else
        begin
            // retire before queueing, so a word accepted on this edge is never matched here
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (pending_xlat.size() == 0)
                begin
                    $error("response word arrived with nothing outstanding");
                    failures++;
                end
                else
                begin
                    want = pending_xlat.pop_front();
                    check_field("forward", want.forward, rsp.forward);
                    check_field("status", want.status, rsp.status);
                    check_field("out_src_address", want.src_address, rsp.out_src_address);
                    check_field("out_dest_address", want.dest_address, rsp.out_dest_address);
                    check_field("out_src_port", want.src_port, rsp.out_src_port);
                    check_field("out_dest_port", want.dest_port, rsp.out_dest_port);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_NAT_ADDRESS)
                begin
                    nat_addr = cfg.data[ADDR_W-1:0];
                end
                else if (cfg.index == CFG_FIRST_PORT)
                begin
                    port_next = cfg.data[PORT_W-1:0];
                end
            end
            if (req.valid && req.ready)
            begin
                fresh = translate_header(req.func, req.src_address, req.dest_address,
                                         req.src_port, req.dest_port);
                pending_xlat.insert(pending_xlat.size(), fresh);
            end
        end
    end

    task automatic print_summary();
        $display("Translated %0d headers: %0d hits, %0d new flows,", results_seen,
                 status_seen[ST_HIT], status_seen[ST_NEW]);
        $display("  %0d unmatched inbound, %0d refused on a full table",
                 status_seen[ST_NO_MATCH], status_seen[ST_FULL]);
        $display("Flow table ended with %0d of %0d entries in use, %0d mismatches",
                 flow_tab.size(), TABLE_DEPTH, failures);
    endtask

endmodule

[tb/sv/nat_port_translation_table_top_test.sv]
// Test top for the NAPT translation table: clock, reset, header and register
// stimulus, response back-pressure and the verdict. Depends on npt_pkg,
// npt_if, the table RTL and nat_port_translation_table_checker.
`timescale 1ns / 1ps

module nat_port_translation_table_top_test;
    import npt_pkg::*;

    localparam int TABLE_DEPTH  = DEF_TABLE_DEPTH;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int PHASE_ITEMS  = 245;
    localparam int HOLD_CYCLES  = 500;
    localparam int STALL_LIMIT  = 4000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = '1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int failures;
    int results_seen;
    int sent_count   = 0;
    int quiet_cycles = 0;
    bit calm         = 1'b0;
    bit hold_pending = 1'b0;

    logic [ADDR_W-1:0] cur_nat;
    logic [PORT_W-1:0] port_bases[$];
    logic [ADDR_W-1:0] flow_addrs[$];
    logic [PORT_W-1:0] flow_ports[$];

    npt_cfg_if cfg_ch();
    npt_req_if req_ch();
    npt_rsp_if rsp_ch();

    nat_port_translation_table_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    nat_port_translation_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_ch),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .failures     (failures),
        .results_seen (results_seen)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    task automatic send_header(input logic func, input logic [ADDR_W-1:0] sa,
                               input logic [ADDR_W-1:0] da, input logic [PORT_W-1:0] sp,
                               input logic [PORT_W-1:0] dp);
        req_ch.valid        <= 1'b1;
        req_ch.func         <= func;
        req_ch.src_address  <= sa;
        req_ch.dest_address <= da;
        req_ch.src_port     <= sp;
        req_ch.dest_port    <= dp;
        do @(posedge clk); while (!req_ch.ready);
        sent_count++;
        // drop valid for a short gap now and then
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // results_seen may lag the response transfer; that only makes the wait longer
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (sent_count != results_seen) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic program_regs(input logic [ADDR_W-1:0] nat, input logic [PORT_W-1:0] base,
                                input bit poke_spare);
        wait_idle();
        write_reg(CFG_NAT_ADDRESS, CFG_DATA_W'(nat));
        write_reg(CFG_FIRST_PORT, CFG_DATA_W'(base));
        if (poke_spare)
        begin
            write_reg(CFG_SPARE, $urandom);
        end
        cfg_ch.valid <= 1'b0;
        cur_nat = nat;
        port_bases.insert(port_bases.size(), base);
    endtask

    task automatic random_header(output logic func, output logic [ADDR_W-1:0] sa,
                                 output logic [ADDR_W-1:0] da, output logic [PORT_W-1:0] sp,
                                 output logic [PORT_W-1:0] dp);
        int pick;
        int k;
        int idx;
        func = FUNC_OUTBOUND;
        sa   = $urandom;
        da   = $urandom;
        sp   = PORT_W'($urandom);
        dp   = PORT_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            // mostly known flows; the rest are new or share address or port with one
            k = $urandom_range(0, 99);
            if (flow_addrs.size() > 0 && k < 55)
            begin
                idx = $urandom_range(0, flow_addrs.size() - 1);
                sa  = flow_addrs[idx];
                sp  = flow_ports[idx];
            end
            else
            begin
                if (flow_addrs.size() > 0 && k < 75)
                begin
                    idx = $urandom_range(0, flow_addrs.size() - 1);
                    if (k < 65) sa = flow_addrs[idx];
                    else sp = flow_ports[idx];
                end
                flow_addrs.insert(flow_addrs.size(), sa);
                flow_ports.insert(flow_ports.size(), sp);
            end
        end
        else if (pick < 93)
        begin
            func = FUNC_INBOUND;
            if ($urandom_range(0, 9) != 0) da = cur_nat;
            else if ($urandom_range(0, 1) == 1) da = cur_nat ^ (32'h1 << $urandom_range(0, 31));
            // aim near the ports handed out so far
            if ($urandom_range(0, 9) < 8)
            begin
                dp = port_bases[$urandom_range(0, port_bases.size() - 1)]
                     + PORT_W'($urandom_range(0, 70));
            end
        end
        else
        begin
            func = 1'($urandom_range(0, 1));
        end
    endtask

    // response side: random stalls, one long hold-off on request
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
                rsp_ch.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no transfer for %0d cycles, giving up", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic              func;
        logic [ADDR_W-1:0] sa;
        logic [ADDR_W-1:0] da;
        logic [PORT_W-1:0] sp;
        logic [PORT_W-1:0] dp;
        int                phase;

        req_ch.valid        <= 1'b0;
        req_ch.func         <= FUNC_OUTBOUND;
        req_ch.src_address  <= '0;
        req_ch.dest_address <= '0;
        req_ch.src_port     <= '0;
        req_ch.dest_port    <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_NAT_ADDRESS;
        cfg_ch.data         <= '0;
        cur_nat = '0;
        port_bases.insert(port_bases.size(), FIRST_PORT_RESET);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: nat_address 0, ports from 10000
        send_header(FUNC_INBOUND, 32'h0A00_0001, 32'h0, 16'd5000, 16'd10000);
        send_header(FUNC_OUTBOUND, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF);
        send_header(FUNC_OUTBOUND, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0);
        send_header(FUNC_OUTBOUND, 32'h0, 32'h0808_0808, 16'h0, 16'd53);
        send_header(FUNC_OUTBOUND, 32'h0, 32'h0808_0404, 16'hFFFF, 16'd443);
        send_header(FUNC_OUTBOUND, 32'hFFFF_FFFF, 32'h0101_0101, 16'h0, 16'd80);
        send_header(FUNC_INBOUND, 32'hC633_6401, 32'h0, 16'd443, 16'd10001);
        send_header(FUNC_INBOUND, 32'hC633_6402, 32'h0, 16'd53, 16'd10000);
        send_header(FUNC_INBOUND, 32'hC633_6403, 32'hFFFF_FFFF, 16'd80, 16'd10000);
        send_header(FUNC_INBOUND, 32'hC633_6404, 32'h0, 16'd80, 16'd9999);
        send_header(FUNC_INBOUND, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'hFFFF);

        // all-ones address, ports from 0, plus a write to an unused index
        program_regs(32'hFFFF_FFFF, 16'd0, 1'b1);
        send_header(FUNC_OUTBOUND, 32'h0A00_0001, 32'h0808_0808, 16'd1234, 16'd53);
        send_header(FUNC_OUTBOUND, 32'h0, 32'h0808_0808, 16'h0, 16'd53);
        send_header(FUNC_INBOUND, 32'h0808_0808, 32'hFFFF_FFFF, 16'd53, 16'd0);
        send_header(FUNC_INBOUND, 32'h0808_0404, 32'hFFFF_FFFF, 16'd443, 16'd10002);

        // reload 10000: the new flow repeats an external port, the older entry answers inbound
        program_regs(32'hFFFF_FFFF, FIRST_PORT_RESET, 1'b0);
        send_header(FUNC_OUTBOUND, 32'h0A00_0002, 32'h0101_0101, 16'd80, 16'd8080);
        send_header(FUNC_INBOUND, 32'h0101_0101, 32'hFFFF_FFFF, 16'd8080, 16'd10000);
        send_header(FUNC_OUTBOUND, 32'h0A00_0002, 32'h0101_0101, 16'd80, 16'd8080);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: program_regs($urandom, 16'd65472, 1'b0);
                1:
                begin
                    program_regs($urandom, PORT_W'($urandom_range(0, 65472)), 1'b1);
                    hold_pending = 1'b1;
                end
                2: program_regs(32'h0, 16'd0, 1'b0);
                default:
                begin
                    calm = 1'b1;
                    program_regs($urandom, PORT_W'($urandom_range(0, 65472)), 1'b0);
                end
            endcase
            repeat (PHASE_ITEMS)
            begin
                random_header(func, sa, da, sp, dp);
                send_header(func, sa, da, sp, dp);
            end
        end

        wait_idle();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        chk.print_summary();
        if (failures == 0 && sent_count == results_seen)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
